// ===== rtl/npg_pkg.sv =====
// Shared types and constants of the next-permutation generator.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package npg_pkg;

   localparam int unsigned DEF_MAX_LEN = 16;
   localparam int unsigned RESET_LEN   = 16;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned IDX_W   = 4;
   localparam int unsigned LEN_W   = 5;
   localparam int unsigned OUT_W   = 4;
   localparam int unsigned STAT_W  = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_IDENTITY = 2'd0,
      CMD_NEXT     = 2'd1,
      CMD_PREV     = 2'd2,
      CMD_SWAP     = 2'd3
   } cmd_type;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_LAST  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/npg_req_if.sv =====
// Command channel of the next-permutation generator.
// Depends on npg_pkg for the field widths.
`default_nettype none

interface npg_req_if import npg_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] index_a;
   logic [IDX_W-1:0] index_b;

   modport source (output valid, command, index_a, index_b, input ready);
   modport sink   (input valid, command, index_a, index_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/npg_rsp_if.sv =====
// Result channel of the next-permutation generator, one transfer per entry.
// Depends on npg_pkg for the field widths.
`default_nettype none

interface npg_rsp_if import npg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  position;
   logic [OUT_W-1:0]  entry_value;
   logic [STAT_W-1:0] status;
   logic              identity_now;
   logic              last_entry;

   modport source (output valid, position, entry_value, status, identity_now, last_entry,
                   input ready);
   modport sink   (input valid, position, entry_value, status, identity_now, last_entry,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/next_permutation_generator.sv =====
// Top level of the next-permutation generator: command sequencer around one scan comparator.
// Depends on npg_pkg, npg_req_if, npg_rsp_if and npg_store.
//
//   channel   direction   handshake         carries
//   req_ch    in          valid / ready     command, index_a, index_b
//   rsp_ch    out         valid / ready     position, entry_value, status, identity_now,
//                                           last_entry (one transfer per entry)
//   csr_*     in          csr_wr_en         perm_len, for the user to write while idle
//
// A command is shortest for set identity and swap and longest for an advance with a
// long scan and a long tail reversal; output stalls add to it. Each scan step reads
// the two-port store and then compares, and each exchange reads both entries and
// then writes them one after the other on its single write port.
// Reset clears the store's valid bits at once; there is no clearing pass.
// req_ch.ready is high only while no command is in progress; csr writes are not gated.
`default_nettype none

module next_permutation_generator import npg_pkg::*; #(
   parameter int unsigned MAX_LEN = DEF_MAX_LEN
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   npg_req_if.sink          req_ch,
   npg_rsp_if.source        rsp_ch
);

   localparam int unsigned IW       = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned RST_USED = (RESET_LEN > MAX_LEN) ? MAX_LEN : RESET_LEN;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_FIND_RD  = 12'b0000_0000_0010,
      ST_FIND_CMP = 12'b0000_0000_0100,
      ST_SUCC_RD  = 12'b0000_0000_1000,
      ST_SUCC_CMP = 12'b0000_0001_0000,
      ST_EX_RD    = 12'b0000_0010_0000,
      ST_EX_W1    = 12'b0000_0100_0000,
      ST_EX_W2    = 12'b0000_1000_0000,
      ST_ID_RD    = 12'b0001_0000_0000,
      ST_ID_CMP   = 12'b0010_0000_0000,
      ST_OUT_RD   = 12'b0100_0000_0000,
      ST_OUT_SEND = 12'b1000_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [IW-1:0]     len_m1_ff, len_m1_in;
   logic [IW-1:0]     ptr_a_ff, ptr_a_in;
   logic [IW-1:0]     ptr_b_ff, ptr_b_in;
   logic              mirror_ff, mirror_in;
   logic              rev_ff, rev_in;
   logic              swap_cmd_ff, swap_cmd_in;
   logic              ident_ff, ident_in;
   logic [STAT_W-1:0] status_ff, status_in;

   logic              clear_store;
   logic              rd_en;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [IW-1:0]     wr_data;
   logic [IW-1:0]     rd_a;
   logic [IW-1:0]     rd_b;
   logic [IW-1:0]     phys_a;
   logic [IW-1:0]     phys_b;
   logic              a_gt_b;
   logic              req_xfer;
   logic              out_of_range;
   logic [31:0]       csr_len;
   logic [IW-1:0]     next_s;
   logic [IW-1:0]     next_r;

   // A mirrored advance works on the permutation read right to left.
   assign phys_a = mirror_ff ? (len_m1_ff - ptr_a_ff) : ptr_a_ff;
   assign phys_b = mirror_ff ? (len_m1_ff - ptr_b_ff) : ptr_b_ff;

   // The one shared comparator used by both scans.
   assign a_gt_b = rd_a > rd_b;

   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign out_of_range = (32'(req_ch.index_a) > 32'(len_m1_ff))
                         || (32'(req_ch.index_b) > 32'(len_m1_ff));
   assign csr_len      = 32'(csr_wr_data);

   always_comb begin
      if (csr_len < 32'd2) begin
         len_m1_in = IW'(1);
      end else if (csr_len > 32'(MAX_LEN)) begin
         len_m1_in = IW'(MAX_LEN - 1);
      end else begin
         len_m1_in = IW'(csr_len - 32'd1);
      end
   end

   always_comb begin
      if (rev_ff) begin
         next_s = ptr_a_ff + IW'(1);
         next_r = ptr_b_ff - IW'(1);
      end else begin
         next_s = ptr_a_ff + IW'(1);
         next_r = len_m1_ff;
      end
   end

   always_comb begin
      state_in    = state_ff;
      ptr_a_in    = ptr_a_ff;
      ptr_b_in    = ptr_b_ff;
      mirror_in   = mirror_ff;
      rev_in      = rev_ff;
      swap_cmd_in = swap_cmd_ff;
      ident_in    = ident_ff;
      status_in   = status_ff;
      clear_store = csr_wr_en;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = phys_a;
      wr_data     = rd_b;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               status_in   = STAT_OK;
               mirror_in   = (req_ch.command == CMD_PREV);
               rev_in      = 1'b0;
               swap_cmd_in = (req_ch.command == CMD_SWAP);
               ident_in    = 1'b1;
               ptr_a_in    = '0;
               unique case (req_ch.command)
                  CMD_IDENTITY: begin
                     clear_store = 1'b1;
                     mirror_in   = 1'b0;
                     state_in    = ST_ID_RD;
                  end
                  CMD_NEXT, CMD_PREV: begin
                     ptr_a_in = len_m1_ff - IW'(1);
                     ptr_b_in = len_m1_ff;
                     state_in = ST_FIND_RD;
                  end
                  CMD_SWAP: begin
                     if (out_of_range) begin
                        status_in = STAT_RANGE;
                        state_in  = ST_ID_RD;
                     end else begin
                        ptr_a_in = IW'(req_ch.index_a);
                        ptr_b_in = IW'(req_ch.index_b);
                        state_in = ST_EX_RD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FIND_RD: begin
            rd_en    = 1'b1;
            state_in = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            // Looking for the rightmost ascent from the right end.
            if (a_gt_b) begin
               if (ptr_a_ff == '0) begin
                  status_in = STAT_LAST;
                  mirror_in = 1'b0;
                  state_in  = ST_ID_RD;
               end else begin
                  ptr_a_in = ptr_a_ff - IW'(1);
                  ptr_b_in = ptr_a_ff;
                  state_in = ST_FIND_RD;
               end
            end else begin
               ptr_b_in = len_m1_ff;
               state_in = ST_SUCC_RD;
            end
         end
         ST_SUCC_RD: begin
            rd_en    = 1'b1;
            state_in = ST_SUCC_CMP;
         end
         ST_SUCC_CMP: begin
            // Walk left until the tail value is larger than the pivot.
            if ((ptr_b_ff > (ptr_a_ff + IW'(1))) && a_gt_b) begin
               ptr_b_in = ptr_b_ff - IW'(1);
               state_in = ST_SUCC_RD;
            end else begin
               state_in = ST_EX_RD;
            end
         end
         ST_EX_RD: begin
            rd_en    = 1'b1;
            state_in = ST_EX_W1;
         end
         ST_EX_W1: begin
            wr_en    = 1'b1;
            wr_addr  = phys_a;
            wr_data  = rd_b;
            state_in = ST_EX_W2;
         end
         ST_EX_W2: begin
            wr_en   = 1'b1;
            wr_addr = phys_b;
            wr_data = rd_a;
            // After the pivot exchange the tail is reversed pair by pair.
            if (!swap_cmd_ff && (next_s < next_r)) begin
               ptr_a_in = next_s;
               ptr_b_in = next_r;
               rev_in   = 1'b1;
               state_in = ST_EX_RD;
            end else begin
               ptr_a_in  = '0;
               mirror_in = 1'b0;
               state_in  = ST_ID_RD;
            end
         end
         ST_ID_RD: begin
            rd_en    = 1'b1;
            state_in = ST_ID_CMP;
         end
         ST_ID_CMP: begin
            ident_in = ident_ff && (rd_a == ptr_a_ff);
            if (ptr_a_ff == len_m1_ff) begin
               ptr_a_in = '0;
               state_in = ST_OUT_RD;
            end else begin
               ptr_a_in = ptr_a_ff + IW'(1);
               state_in = ST_ID_RD;
            end
         end
         ST_OUT_RD: begin
            rd_en    = 1'b1;
            state_in = ST_OUT_SEND;
         end
         ST_OUT_SEND: begin
            if (rsp_ch.ready) begin
               if (ptr_a_ff == len_m1_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_a_in = ptr_a_ff + IW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         len_m1_ff <= IW'(RST_USED - 1);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            len_m1_ff <= len_m1_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_a_ff    <= ptr_a_in;
      ptr_b_ff    <= ptr_b_in;
      mirror_ff   <= mirror_in;
      rev_ff      <= rev_in;
      swap_cmd_ff <= swap_cmd_in;
      ident_ff    <= ident_in;
      status_ff   <= status_in;
   end

   npg_store #(
      .DEPTH (MAX_LEN),
      .AW    (IW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear_store),
      .rd_en     (rd_en),
      .rd_addr_a (phys_a),
      .rd_addr_b (phys_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = (state_ff == ST_OUT_SEND);
   assign rsp_ch.position     = OUT_W'(ptr_a_ff);
   assign rsp_ch.entry_value  = OUT_W'(rd_a);
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.identity_now = ident_ff;
   assign rsp_ch.last_entry   = (ptr_a_ff == len_m1_ff);

endmodule

`default_nettype wire

// ===== rtl/npg_store.sv =====
// Permutation store: one write port, two registered read ports.
// Per-entry valid bits make an unwritten entry read as its own index.
`default_nettype none

module npg_store #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [AW-1:0] rd_data_a,
   output logic [AW-1:0] rd_data_b,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data
);

   logic [AW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [AW-1:0]    rd_a_ff;
   logic [AW-1:0]    rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= valid_ff[rd_addr_a] ? mem[rd_addr_a] : rd_addr_a;
         rd_b_ff <= valid_ff[rd_addr_b] ? mem[rd_addr_b] : rd_addr_b;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire
